### rtl/slse_pkg.sv
// Shared types, constants and codes of the shortened LDPC systematic encoder.
package slse_pkg;

  // Default code dimensions.
  localparam int INFO_BITS_DEF   = 7136;
  localparam int PARITY_BITS_DEF = 1022;
  localparam int WORD_BITS_DEF   = 64;

  // Fixed field widths of the transfer payloads.
  localparam int ACT_W   = 2;
  localparam int COL_W   = 13;
  localparam int GWORD_W = 4;
  localparam int DATA_W  = 64;
  localparam int KIND_W  = 2;
  localparam int RUN_W   = 13;

  // Input action codes.
  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_INFO   = 2'd1,
    ACT_FINISH = 2'd2
  } action_e;

  // Result kind codes.
  typedef enum logic [KIND_W-1:0] {
    KIND_ECHO   = 2'd0,
    KIND_RUN    = 2'd1,
    KIND_PARITY = 2'd2
  } kind_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ECHO,
    ST_XOR,
    ST_DRAIN,
    ST_RUN,
    ST_CLOSE_RD,
    ST_CLOSE_OUT
  } state_e;

  // Input item.
  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic               data_bit;
    logic [COL_W-1:0]   gen_column;
    logic [GWORD_W-1:0] gen_word;
    logic [DATA_W-1:0]  gen_data;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] out_word;
    logic [RUN_W-1:0]  run_length;
    logic              block_end;
  } out_item_t;

endpackage

### rtl/slse_in_if.sv
// Valid/ready channel that carries input items.
interface slse_in_if;
  import slse_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

### rtl/slse_out_if.sv
// Valid/ready channel that carries result items.
interface slse_out_if;
  import slse_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

### rtl/slse_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module slse_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data register holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/shortened_ldpc_systematic_encoder.sv
// Top level of the shortened systematic LDPC encoder.
//
// Usage: one input channel (in_i) and one result channel (out_o), both
// valid/ready; a transfer happens on a rising edge with valid and ready high.
// A load action with column and word in range writes one generator word into
// the generator memory; a load returns no result. An info action returns an
// echo of the bit; a set bit then folds its generator column into the parity
// memory, one word per cycle through the single read port of the generator
// memory. When the block is full, or on a finish action with a partial block
// (after a zero-run result), the parity words are returned one by one, each
// read from the parity memory and then issued, last word flagged.
// One item is worked on at a time; a new item is taken only in the idle state.
// Results pass through a single output register, so the block keeps working
// while a result waits and only stalls when a second result is due.
// Reset clears the bit position and the parity valid flags, which makes the
// parity memory read as zero; the generator memory keeps its contents and
// must be loaded before use. No clearing pass is needed.
module shortened_ldpc_systematic_encoder #(
  parameter int INFO_BITS   = slse_pkg::INFO_BITS_DEF,
  parameter int PARITY_BITS = slse_pkg::PARITY_BITS_DEF,
  parameter int WORD_BITS   = slse_pkg::WORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slse_in_if.sink     in_i,
  slse_out_if.source  out_o
);
  import slse_pkg::*;

  localparam int PAR_WORDS  = (PARITY_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int GEN_DEPTH  = INFO_BITS * PAR_WORDS;
  localparam int ADDR_W     = GEN_DEPTH > 1 ? $clog2(GEN_DEPTH) : 1;
  localparam int BASE_W     = $clog2(GEN_DEPTH + 1);
  localparam int IDX_W      = PAR_WORDS > 1 ? $clog2(PAR_WORDS) : 1;
  localparam int POS_W      = $clog2(INFO_BITS + 1);
  localparam int LAST_VALID = PARITY_BITS - (PAR_WORDS - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_MASK =
    {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_VALID);

  state_e                state_q, state_d;
  logic                  bit_q;
  logic [POS_W-1:0]      pos_q;
  logic [BASE_W-1:0]     base_q;
  logic [IDX_W-1:0]      w_q;
  logic                  wb_pend_q;
  logic [IDX_W-1:0]      wb_idx_q;
  logic [PAR_WORDS-1:0]  acc_vld_q;
  logic                  out_valid_q;
  out_item_t             out_item_q;

  logic                  in_acc;
  logic                  out_free;
  logic                  out_ld;
  out_item_t             out_d;
  logic                  w_last;
  logic                  load_ok;

  logic                  gen_we, gen_re;
  logic [ADDR_W-1:0]     gen_waddr, gen_raddr;
  logic [WORD_BITS-1:0]  gen_wdata, gen_rdata;
  logic                  acc_we, acc_re;
  logic [IDX_W-1:0]      acc_raddr;
  logic [WORD_BITS-1:0]  acc_wdata, acc_rdata;
  logic [WORD_BITS-1:0]  par_word;

  // Handshake helpers.
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign w_last   = (w_q == IDX_W'(PAR_WORDS - 1));

  // Load range check and address of the loaded generator word.
  assign load_ok   = (32'(in_i.item.gen_column) < 32'(INFO_BITS)) &&
                     (32'(in_i.item.gen_word) < 32'(PAR_WORDS));
  assign gen_waddr = ADDR_W'(32'(in_i.item.gen_column) * 32'(PAR_WORDS) +
                             32'(in_i.item.gen_word));
  assign gen_wdata = WORD_BITS'(in_i.item.gen_data);
  assign gen_raddr = ADDR_W'(base_q + BASE_W'(w_q));

  // Parity update: the word read last cycle is combined with its column word.
  assign acc_we    = wb_pend_q;
  assign acc_wdata = gen_rdata ^ (acc_vld_q[wb_idx_q] ? acc_rdata : '0);

  // Closing word with the fill bits above the parity length forced to zero.
  assign par_word = acc_vld_q[w_q] ? (acc_rdata & (w_last ? LAST_MASK : '1)) : '0;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_i.item.action)
            ACT_INFO:   state_d = ST_ECHO;
            ACT_FINISH: state_d = (pos_q != '0) ? ST_RUN : ST_IDLE;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_ECHO: begin
        if (out_free) begin
          if (bit_q) begin
            state_d = ST_XOR;
          end else if (pos_q + POS_W'(1) == POS_W'(INFO_BITS)) begin
            state_d = ST_CLOSE_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_XOR: begin
        if (w_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = (pos_q == POS_W'(INFO_BITS)) ? ST_CLOSE_RD : ST_IDLE;
      end
      ST_RUN: begin
        if (out_free) begin
          state_d = ST_CLOSE_RD;
        end
      end
      ST_CLOSE_RD: begin
        state_d = ST_CLOSE_OUT;
      end
      ST_CLOSE_OUT: begin
        if (out_free) begin
          state_d = w_last ? ST_IDLE : ST_CLOSE_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output and memory control for each state.
  always_comb begin
    in_i.ready = 1'b0;
    gen_we     = 1'b0;
    gen_re     = 1'b0;
    acc_re     = 1'b0;
    acc_raddr  = w_q;
    out_ld     = 1'b0;
    out_d      = '0;
    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        gen_we     = in_i.valid && (in_i.item.action == ACT_LOAD) && load_ok;
      end
      ST_ECHO: begin
        out_ld         = out_free;
        out_d.kind     = KIND_ECHO;
        out_d.out_word = DATA_W'(bit_q);
      end
      ST_XOR: begin
        gen_re = 1'b1;
        acc_re = 1'b1;
      end
      ST_RUN: begin
        out_ld           = out_free;
        out_d.kind       = KIND_RUN;
        out_d.run_length = RUN_W'(POS_W'(INFO_BITS) - pos_q);
      end
      ST_CLOSE_RD: begin
        acc_re = 1'b1;
      end
      ST_CLOSE_OUT: begin
        out_ld          = out_free;
        out_d.kind      = KIND_PARITY;
        out_d.out_word  = DATA_W'(par_word);
        out_d.block_end = w_last;
      end
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  // Control registers; the column base moves on with every info bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      base_q    <= '0;
      w_q       <= '0;
      wb_pend_q <= 1'b0;
      acc_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      wb_pend_q <= (state_q == ST_XOR);
      if (state_q == ST_ECHO && out_free) begin
        pos_q <= pos_q + POS_W'(1);
        if (!bit_q) begin
          base_q <= base_q + BASE_W'(PAR_WORDS);
        end
      end
      if (state_q == ST_DRAIN) begin
        base_q <= base_q + BASE_W'(PAR_WORDS);
      end
      if (state_q == ST_XOR) begin
        w_q <= w_last ? '0 : w_q + IDX_W'(1);
      end
      if (acc_we) begin
        acc_vld_q[wb_idx_q] <= 1'b1;
      end
      if (state_q == ST_CLOSE_OUT && out_free) begin
        acc_vld_q[w_q] <= 1'b0;
        w_q            <= w_last ? '0 : w_q + IDX_W'(1);
        if (w_last) begin
          pos_q  <= '0;
          base_q <= '0;
        end
      end
    end
  end

  // Payload registers of the item in work and of the pending parity write.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      bit_q <= in_i.item.data_bit;
    end
    wb_idx_q <= w_q;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_item_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

  // Generator memory: one word per info position and parity word.
  slse_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (GEN_DEPTH)
  ) u_gen_ram (
    .clk_i   (clk_i),
    .we_i    (gen_we),
    .waddr_i (gen_waddr),
    .wdata_i (gen_wdata),
    .re_i    (gen_re),
    .raddr_i (gen_raddr),
    .rdata_o (gen_rdata)
  );

  // Parity accumulator memory.
  slse_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (PAR_WORDS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (wb_idx_q),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  // The bit position never runs past the block length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(INFO_BITS))
    else $error("bit position beyond block length");

  // A parity write never targets the word being read in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_we && acc_re) |-> (wb_idx_q != acc_raddr))
    else $error("parity read and write collide");

  // No parity update is still in flight while the block is being closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLOSE_RD || state_q == ST_CLOSE_OUT) |-> !acc_we)
    else $error("parity write during block close");

  // Generator loads and column reads never share a cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(gen_we && gen_re))
    else $error("generator load during column read");

  // After the last parity word is issued the next block starts empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ld && out_d.block_end) |=> (pos_q == '0 && acc_vld_q == '0))
    else $error("block state not cleared after close");

endmodule

### sim/slse_encoder_checker.sv
// Checker that predicts the encoder's results and compares them with every result transfer.
module slse_encoder_checker
  import slse_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  slse_in_if   in_mon,
  slse_out_if  out_mon,
  output int   fail_cnt_o,
  output int   pending_o,
  output int   items_o,
  output int   results_o,
  output int   blocks_o,
  output int   runs_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int INFO_BITS   = INFO_BITS_DEF;
  localparam int PARITY_BITS = PARITY_BITS_DEF;
  localparam int WORD_BITS   = WORD_BITS_DEF;
  localparam int PAR_WORDS   = (PARITY_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam logic [DATA_W-1:0] WORD_MASK = {DATA_W{1'b1}} >> (DATA_W - WORD_BITS);
  localparam int MAX_REPORTS = 100;

  // Predicted encoder state; the generator store survives reset.
  bit [DATA_W-1:0] gen_store [INFO_BITS*PAR_WORDS];
  bit [DATA_W-1:0] parity_acc [PAR_WORDS];
  int unsigned     bit_pos;
  out_item_t       results_due [$];

  int fail_cnt    = 0;
  int due_cnt     = 0;
  int items_cnt   = 0;
  int results_cnt = 0;
  int blocks_cnt  = 0;
  int runs_cnt    = 0;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = due_cnt;
  assign items_o    = items_cnt;
  assign results_o  = results_cnt;
  assign blocks_o   = blocks_cnt;
  assign runs_o     = runs_cnt;

  // Prints one line per mismatch, up to a cap, and counts them all.
  task automatic report_mismatch(input string msg);
    if (fail_cnt < MAX_REPORTS) begin
      $display("%0t MISMATCH: %s", $time, msg);
    end
    fail_cnt++;
  endtask

  function automatic void push_result(input kind_e k, input logic [DATA_W-1:0] word,
                                      input logic [RUN_W-1:0] run, input logic last);
    out_item_t res;
    res.kind       = k;
    res.out_word   = word;
    res.run_length = run;
    res.block_end  = last;
    results_due.push_back(res);
  endfunction

  // Closing a block returns all parity words, fill bits above the parity length zero.
  function automatic void emit_parity_words();
    int              valid_bits;
    logic [DATA_W-1:0] mask;
    for (int w = 0; w < PAR_WORDS; w++) begin
      valid_bits = PARITY_BITS - w * WORD_BITS;
      if (valid_bits > WORD_BITS) begin
        valid_bits = WORD_BITS;
      end
      mask = {DATA_W{1'b1}} >> (DATA_W - valid_bits);
      push_result(KIND_PARITY, parity_acc[w] & mask, '0, (w == PAR_WORDS - 1));
      parity_acc[w] = '0;
    end
    bit_pos = 0;
  endfunction

  // Works out the results of one accepted input item.
  function automatic void encode_item(input in_item_t it);
    case (it.action)
      ACT_LOAD: begin
        if (it.gen_column < INFO_BITS && it.gen_word < PAR_WORDS) begin
          gen_store[it.gen_column * PAR_WORDS + it.gen_word] = it.gen_data & WORD_MASK;
        end
      end
      ACT_INFO: begin
        push_result(KIND_ECHO, {{(DATA_W-1){1'b0}}, it.data_bit}, '0, 1'b0);
        if (it.data_bit && bit_pos < INFO_BITS) begin
          for (int w = 0; w < PAR_WORDS; w++) begin
            parity_acc[w] ^= gen_store[bit_pos * PAR_WORDS + w];
          end
        end
        bit_pos++;
        if (bit_pos >= INFO_BITS) begin
          emit_parity_words();
        end
      end
      ACT_FINISH: begin
        // A finish on an empty block returns nothing.
        if (bit_pos != 0) begin
          push_result(KIND_RUN, '0, RUN_W'(INFO_BITS - bit_pos), 1'b0);
          emit_parity_words();
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Compares one result transfer with the oldest expectation.
  task automatic check_result(input out_item_t got);
    out_item_t want;
    results_cnt++;
    if (results_due.size() == 0) begin
      report_mismatch($sformatf("result %0d not expected: kind %0d word %h run %0d end %0d",
                                results_cnt, got.kind, got.out_word, got.run_length,
                                got.block_end));
      return;
    end
    want = results_due.pop_front();
    if (got.kind !== want.kind) begin
      report_mismatch($sformatf("result %0d kind %0d, want %0d",
                                results_cnt, got.kind, want.kind));
    end
    if (got.out_word !== want.out_word) begin
      report_mismatch($sformatf("result %0d out_word %h, want %h",
                                results_cnt, got.out_word, want.out_word));
    end
    if (got.run_length !== want.run_length) begin
      report_mismatch($sformatf("result %0d run_length %0d, want %0d",
                                results_cnt, got.run_length, want.run_length));
    end
    if (got.block_end !== want.block_end) begin
      report_mismatch($sformatf("result %0d block_end %0d, want %0d",
                                results_cnt, got.block_end, want.block_end));
    end
    if (want.block_end) begin
      blocks_cnt++;
    end
    if (want.kind == KIND_RUN) begin
      runs_cnt++;
    end
  endtask

  // Watch both channels at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_pos = 0;
      for (int w = 0; w < PAR_WORDS; w++) begin
        parity_acc[w] = '0;
      end
      results_due.delete();
      due_cnt <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        check_result(out_mon.item);
      end
      if (in_mon.valid && in_mon.ready) begin
        items_cnt++;
        encode_item(in_mon.item);
      end
      due_cnt <= results_due.size();
    end
  end

endmodule

### sim/tb_shortened_ldpc_systematic_encoder.sv
// Testbench top: drives input transfers, paces result transfers and reports the verdict.
module tb_shortened_ldpc_systematic_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import slse_pkg::*;

  localparam int INFO_BITS = INFO_BITS_DEF;
  localparam int PAR_WORDS = (PARITY_BITS_DEF + WORD_BITS_DEF - 1) / WORD_BITS_DEF;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  // Columns 0 .. LOW_COLS-1 are loaded in full and serve the short blocks.
  localparam int LOW_COLS     = 4;
  localparam int RAND_A       = 10;
  localparam int RAND_B       = 10;
  localparam int RAND_C       = 5;
  localparam int PRESS_BITS   = 4;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 100;
  localparam longint LIMIT_CYCLES = 2_000_000;

  logic clk = 1'b0;
  logic rst_n;

  slse_in_if  in_ch ();
  slse_out_if out_ch ();

  int fail_cnt;
  int pending;
  int items;
  int results;
  int blocks;
  int runs;

  int          tx_idle_pct = 14;
  int          rx_idle_pct = 47;
  int          hold_left;
  bit          hold_req = 1'b0;
  longint      cycles = 0;
  // Which words of each generator column have been written, and the block position.
  bit [PAR_WORDS-1:0] col_words [INFO_BITS];
  int unsigned        stim_pos = 0;

  shortened_ldpc_systematic_encoder u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  slse_encoder_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .items_o    (items),
    .results_o  (results),
    .blocks_o   (blocks),
    .runs_o     (runs)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= rst_n && (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // The hold-off counts down in cycles once requested.
  initial begin
    hold_left = 0;
    wait (hold_req);
    @(posedge clk);
    hold_left <= HOLD_CYCLES;
    repeat (HOLD_CYCLES) begin
      @(posedge clk);
      hold_left <= hold_left - 1;
    end
  end

  function automatic in_item_t noise_item();
    in_item_t it;
    it.action     = ACT_W'($urandom_range(0, (1 << ACT_W) - 1));
    it.data_bit   = 1'($urandom_range(0, 1));
    it.gen_column = COL_W'($urandom_range(0, (1 << COL_W) - 1));
    it.gen_word   = GWORD_W'($urandom_range(0, (1 << GWORD_W) - 1));
    it.gen_data   = {$urandom, $urandom};
    return it;
  endfunction

  // A set bit is only sent where the whole generator column is written.
  function automatic logic pick_bit();
    if (col_words[stim_pos] == '1) begin
      return 1'($urandom_range(0, 1));
    end
    return 1'b0;
  endfunction

  // Offers one item, with random gaps, until it is taken; then tracks the block position.
  task automatic send(input in_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= it;
    do @(posedge clk); while (!in_ch.ready);
    case (it.action)
      ACT_LOAD: begin
        if (it.gen_column < INFO_BITS && it.gen_word < PAR_WORDS) begin
          col_words[it.gen_column][it.gen_word] = 1'b1;
        end
      end
      ACT_INFO:   stim_pos = (stim_pos + 1 == INFO_BITS) ? 0 : stim_pos + 1;
      ACT_FINISH: stim_pos = 0;
      default: begin
      end
    endcase
  endtask

  task automatic send_load(input int col, input int wd, input logic [DATA_W-1:0] data);
    in_item_t it;
    it            = noise_item();
    it.action     = ACT_LOAD;
    it.gen_column = COL_W'(col);
    it.gen_word   = GWORD_W'(wd);
    it.gen_data   = data;
    send(it);
  endtask

  task automatic send_bit(input logic b);
    in_item_t it;
    it          = noise_item();
    it.action   = ACT_INFO;
    it.data_bit = b;
    send(it);
  endtask

  task automatic send_finish();
    in_item_t it;
    it        = noise_item();
    it.action = ACT_FINISH;
    send(it);
  endtask

  task automatic send_unused();
    in_item_t it;
    it        = noise_item();
    it.action = ACT_UNUSED;
    send(it);
  endtask

  // Mostly short blocks with random content, mixed with reloads and noise.
  task automatic random_items(input int n);
    int r;
    int col;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        send_bit(pick_bit());
      end else if (r < 74) begin
        send_finish();
      end else if (r < 92) begin
        col = $urandom_range(0, 1) ? $urandom_range(0, LOW_COLS - 1)
                                   : $urandom_range(0, (1 << COL_W) - 1);
        send_load(col, $urandom_range(0, PAR_WORDS - 1), {$urandom, $urandom});
      end else begin
        send_unused();
      end
    end
  endtask

  // Stimulus.
  initial begin
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.item  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the generator columns used later; column 0 is all ones.
    for (int c = 0; c < LOW_COLS; c++) begin
      for (int w = 0; w < PAR_WORDS; w++) begin
        send_load(c, w, (c == 0) ? {DATA_W{1'b1}} : {$urandom, $urandom});
      end
    end

    // Directed cases: empty finish, unused action, loads out of range, short blocks.
    send_finish();
    send_unused();
    send_load(INFO_BITS, PAR_WORDS - 1, {DATA_W{1'b1}});
    send_load((1 << COL_W) - 1, 0, {DATA_W{1'b1}});
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b1);
    send_finish();
    send_finish();
    send_bit(1'b0);
    send_finish();
    send_load(0, 0, 64'h8000_0000_0000_0001);
    send_load(0, PAR_WORDS - 1, '0);
    send_bit(1'b1);
    send_bit(1'b1);
    send_bit(1'b1);
    send_finish();

    random_items(RAND_A);

    // The idle rates swap sides.
    tx_idle_pct = 47;
    rx_idle_pct = 14;
    random_items(RAND_B);

    // No idling, and the result side stops for a while so the block backs up.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    repeat (PRESS_BITS) begin
      send_bit(pick_bit());
    end
    send_finish();
    random_items(RAND_C);
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d input transfers and %0d result transfers, %0d code blocks closed",
             items, results, blocks);
    $display("(%0d by a finish with a zero run), under three idle patterns and a %0d-cycle hold.",
             runs, HOLD_CYCLES);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
